[design/fcags_pkg.sv]
// Shared types and constants for the fragment chain scorer.
// Used by fcags_penalty and fragment_chain_affine_gap_score_core; no dependencies.
package fcags_pkg;

	localparam int CFG_W   = 24;  // penalty register width
	localparam int SCORE_W = 32;  // fragment score width
	localparam int PEN_W   = 47;  // rounded penalty width, saturating
	localparam int OUT_W   = 47;  // chain score width
	localparam int RUN_W   = 63;  // running score, signed
	localparam int PDATA_W = 32;
	localparam int PADDR_W = 4;

	localparam logic [CFG_W-1:0] MISMATCH_RESET   = CFG_W'(256);
	localparam logic [CFG_W-1:0] GAP_OPEN_RESET   = CFG_W'(0);
	localparam logic [CFG_W-1:0] GAP_EXTEND_RESET = CFG_W'(256);

	typedef enum logic [1:0] {
		REG_MISMATCH   = 2'd0,
		REG_GAP_OPEN   = 2'd1,
		REG_GAP_EXTEND = 2'd2
	} cfg_reg_t;

	// Load enables for the two registers inside a penalty unit.
	typedef struct packed {
		logic load_s3;
		logic load_s4;
	} pen_ctl_t;

endpackage

[design/fragment_chain_affine_gap_score_core.sv]
// Fragment chain scorer with affine gap and mismatch penalties, top level.
// Depends on fcags_pkg and fcags_penalty.
//
//   channel    handshake                      contents
//   fragment   fragment_valid/fragment_ready  query/subject start and end, score, last flag
//   chain      chain_valid/chain_ready        chain_score, one per chain, on its last fragment
//   config     APB (psel/penable/pwrite)      mismatch, gap open, gap extend penalties
//
// One fragment is taken per cycle unless a stalled chain score backs up the pipeline. A
// chain score reaches the output register through the input register, diagonal stage,
// multiply, rounding, then the running-score update that loads the output register.
// arst_n clears all stage valids, the chain state and the penalty registers to defaults.
// A stalled score blocks stage 4 only on a last fragment; earlier stages fill bubbles first.
module fragment_chain_affine_gap_score_core import fcags_pkg::*; #(
	parameter int COORD_BITS = 31,
	parameter int FRAC_BITS  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fragment_valid,
	output logic                  fragment_ready,
	input  logic [COORD_BITS-1:0] query_start,
	input  logic [COORD_BITS-1:0] query_end,
	input  logic [COORD_BITS-1:0] subject_start,
	input  logic [COORD_BITS-1:0] subject_end,
	input  logic [SCORE_W-1:0]    fragment_score,
	input  logic                  last_fragment,
	output logic                  chain_valid,
	input  logic                  chain_ready,
	output logic [OUT_W-1:0]      chain_score,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready
);

	localparam int GW    = COORD_BITS + 1;  // gap magnitude width
	localparam int DW    = COORD_BITS + 2;  // signed diagonal width
	localparam int SUM_W = RUN_W + 3;
	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	// Configuration registers
	logic [CFG_W-1:0] mismatch_q, gap_open_q, gap_extend_q;
	logic             cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mismatch_q   <= MISMATCH_RESET;
			gap_open_q   <= GAP_OPEN_RESET;
			gap_extend_q <= GAP_EXTEND_RESET;
		end else if (cfg_write) begin
			case (cfg_reg_t'(paddr[3:2]))
				REG_MISMATCH:   mismatch_q   <= pwdata[CFG_W-1:0];
				REG_GAP_OPEN:   gap_open_q   <= pwdata[CFG_W-1:0];
				REG_GAP_EXTEND: gap_extend_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_reg_t'(paddr[3:2]))
			REG_MISMATCH:   prdata = PDATA_W'(mismatch_q);
			REG_GAP_OPEN:   prdata = PDATA_W'(gap_open_q);
			REG_GAP_EXTEND: prdata = PDATA_W'(gap_extend_q);
			default:        prdata = '0;
		endcase
	end

	// Pipeline control: each stage moves when the one after it is empty or moving.
	logic v_s1, v_s2, v_s3, v_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic first_s2, first_s3, first_s4;
	logic adv1, adv2, adv3, adv4;
	logic free1, free2, free3, free4;
	logic out_valid_q;
	logic accept;

	// Only a last fragment needs room in the output register.
	assign adv4  = v_s4 && (!last_s4 || !out_valid_q || chain_ready);
	assign free4 = !v_s4 || adv4;
	assign adv3  = v_s3 && free4;
	assign free3 = !v_s3 || adv3;
	assign adv2  = v_s2 && free3;
	assign free2 = !v_s2 || adv2;
	assign adv1  = v_s1 && free2;
	assign free1 = !v_s1 || adv1;

	assign fragment_ready = free1;
	assign accept         = fragment_valid && free1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept || (v_s1 && !adv1);
			v_s2 <= adv1 || (v_s2 && !adv2);
			v_s3 <= adv2 || (v_s3 && !adv3);
			v_s4 <= adv3 || (v_s4 && !adv4);
		end
	end

	// Stage 1: input register
	logic [COORD_BITS-1:0] qs_s1, qe_s1, ss_s1, se_s1;
	logic [SCORE_W-1:0]    fscore_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			qs_s1     <= query_start;
			qe_s1     <= query_end;
			ss_s1     <= subject_start;
			se_s1     <= subject_end;
			fscore_s1 <= fragment_score;
			last_s1   <= last_fragment;
		end
	end

	// Stage 2: diagonal shift and unaligned distance against the previous fragment.
	logic                  have_prev_q;
	logic [COORD_BITS-1:0] prev_qe_q, prev_se_q;
	logic signed [DW-1:0]  diag_prev, diag_cur, diag_diff;
	logic signed [GW-1:0]  dist_diff;
	logic [GW-1:0]         gap_next;
	logic [COORD_BITS-1:0] mis_next;

	always_comb begin
		diag_prev = signed'(DW'(prev_qe_q)) - signed'(DW'(prev_se_q));
		diag_cur  = signed'(DW'(qs_s1)) - signed'(DW'(ss_s1));
		diag_diff = diag_prev - diag_cur;
		if (diag_diff[DW-1]) begin
			gap_next = GW'(-diag_diff);
		end else begin
			gap_next = GW'(diag_diff);
		end
		if (diag_prev > diag_cur) begin
			dist_diff = signed'(GW'(qs_s1)) - signed'(GW'(prev_qe_q));
		end else begin
			dist_diff = signed'(GW'(ss_s1)) - signed'(GW'(prev_se_q));
		end
		if (dist_diff[GW-1]) begin
			mis_next = '0;
		end else begin
			mis_next = dist_diff[COORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_qe_q   <= '0;
			prev_se_q   <= '0;
		end else if (adv1) begin
			have_prev_q <= !last_s1;
			prev_qe_q   <= last_s1 ? '0 : qe_s1;
			prev_se_q   <= last_s1 ? '0 : se_s1;
		end
	end

	logic [GW-1:0]         gap_s2;
	logic [COORD_BITS-1:0] mis_s2;
	logic [SCORE_W-1:0]    fscore_s2, fscore_s3, fscore_s4;

	always_ff @(posedge clk) begin
		if (adv1) begin
			gap_s2    <= gap_next;
			mis_s2    <= mis_next;
			fscore_s2 <= fscore_s1;
			first_s2  <= !have_prev_q;
			last_s2   <= last_s1;
		end
	end

	// Stages 3 and 4: penalty products, then rounding, inside the penalty units.
	pen_ctl_t         pen_ctl;
	logic [PEN_W-1:0] gap_pen, mis_pen;

	assign pen_ctl = '{load_s3: adv2, load_s4: adv3};

	fcags_penalty #(
		.COUNT_W   (GW),
		.FRAC_BITS (FRAC_BITS)
	) u_gap_pen (
		.clk   (clk),
		.ctl   (pen_ctl),
		.base  (gap_open_q),
		.rate  (gap_extend_q),
		.count (gap_s2),
		.pen   (gap_pen)
	);

	fcags_penalty #(
		.COUNT_W   (COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_mis_pen (
		.clk   (clk),
		.ctl   (pen_ctl),
		.base  ('0),
		.rate  (mismatch_q),
		.count (mis_s2),
		.pen   (mis_pen)
	);

	always_ff @(posedge clk) begin
		if (adv2) begin
			fscore_s3 <= fscore_s2;
			first_s3  <= first_s2;
			last_s3   <= last_s2;
		end
		if (adv3) begin
			fscore_s4 <= fscore_s3;
			first_s4  <= first_s3;
			last_s4   <= last_s3;
		end
	end

	// Running score update and output register.
	logic signed [RUN_W-1:0] running_q;
	logic signed [RUN_W-1:0] run_next;
	logic signed [SUM_W-1:0] run_sum;
	logic [OUT_W-1:0]        score_next;
	logic [OUT_W-1:0]        chain_score_q;

	always_comb begin
		run_sum = signed'(SUM_W'(running_q)) + signed'(SUM_W'(fscore_s4))
			- signed'(SUM_W'(gap_pen)) - signed'(SUM_W'(mis_pen));
		if (first_s4) begin
			run_next = signed'(RUN_W'(fscore_s4));
		end else if ((&run_sum[SUM_W-1:RUN_W-1]) || !(|run_sum[SUM_W-1:RUN_W-1])) begin
			run_next = run_sum[RUN_W-1:0];
		end else if (run_sum[SUM_W-1]) begin
			run_next = {1'b1, {(RUN_W-1){1'b0}}};
		end else begin
			run_next = {1'b0, {(RUN_W-1){1'b1}}};
		end
		// Negative or zero totals report as zero; large ones saturate.
		if (run_next[RUN_W-1] || (run_next == '0)) begin
			score_next = '0;
		end else if (|run_next[RUN_W-2:OUT_W]) begin
			score_next = OUT_MAX;
		end else begin
			score_next = run_next[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv4) begin
				running_q <= last_s4 ? '0 : run_next;
			end
			if (adv4 && last_s4) begin
				out_valid_q <= 1'b1;
			end else if (chain_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv4 && last_s4) begin
			chain_score_q <= score_next;
		end
	end

	assign chain_valid = out_valid_q;
	assign chain_score = chain_score_q;

endmodule

[design/fcags_penalty.sv]
// Penalty unit: round((base + rate * count) / 2^FRAC_BITS), ties to even, saturating.
// Two registered stages (product, rounded result). Depends on fcags_pkg.
module fcags_penalty import fcags_pkg::*; #(
	parameter int COUNT_W   = 32,
	parameter int FRAC_BITS = 8
) (
	input  logic               clk,
	input  pen_ctl_t           ctl,
	input  logic [CFG_W-1:0]   base,
	input  logic [CFG_W-1:0]   rate,
	input  logic [COUNT_W-1:0] count,
	output logic [PEN_W-1:0]   pen
);

	localparam int MW = CFG_W + COUNT_W;
	localparam int XW = MW + 1;
	localparam int QW = XW - FRAC_BITS;
	localparam int SW = (QW > PEN_W) ? QW : PEN_W;
	localparam logic [PEN_W-1:0] PEN_MAX = '1;

	logic [MW-1:0]    prod;
	logic [XW-1:0]    total_s3;
	logic [QW-1:0]    rounded;
	logic [SW-1:0]    rounded_w;
	logic [PEN_W-1:0] pen_next;
	logic [PEN_W-1:0] pen_s4;

	assign prod = MW'(rate) * MW'(count);

	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			total_s3 <= XW'(base) + XW'(prod);
		end
	end

	generate
		if (FRAC_BITS == 0) begin : g_no_frac
			assign rounded = total_s3;
		end else begin : g_frac
			localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);
			logic [QW-1:0]        quot;
			logic [FRAC_BITS-1:0] rem;
			logic                 round_up;
			assign quot     = total_s3[XW-1:FRAC_BITS];
			assign rem      = total_s3[FRAC_BITS-1:0];
			assign round_up = (rem > HALF) || ((rem == HALF) && quot[0]);
			assign rounded  = quot + QW'(round_up);
		end
	endgenerate

	always_comb begin
		rounded_w = SW'(rounded);
		if (rounded_w > SW'(PEN_MAX)) begin
			pen_next = PEN_MAX;
		end else begin
			pen_next = rounded_w[PEN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s4) begin
			pen_s4 <= pen_next;
		end
	end

	assign pen = pen_s4;

endmodule

[sim/tb_fragment_chain_affine_gap_score_core.sv]
// Self-checking testbench for fragment_chain_affine_gap_score_core: directed table, random
// chains under several idle/stall patterns, and a long receiver hold-off.
// Depends on fcags_pkg and the core; reads no files.
module tb_fragment_chain_affine_gap_score_core import fcags_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_BITS = 31;
	localparam int FRAC_BITS  = 8;

	localparam int RESET_CYCLES  = 6;
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int MAX_REPORTS   = 10;
	localparam int N_PHASES      = 8;
	localparam int PHASE_ITEMS   = 225;
	localparam int PRESSURE_PHASE = 4;
	localparam int HOLD_CYCLES   = 400;

	localparam logic [COORD_BITS-1:0] C_MAX = '1;
	localparam logic [SCORE_W-1:0]    S_MAX = '1;
	localparam logic [CFG_W-1:0]      P_MAX = '1;
	localparam logic [OUT_W-1:0]      OUT_MAX = '1;
	localparam logic [PEN_W-1:0]      PEN_SAT = '1;
	localparam logic [FRAC_BITS-1:0]  HALF_ULP = FRAC_BITS'(1) << (FRAC_BITS - 1);
	localparam longint RUN_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam longint RUN_MIN = -RUN_MAX - 1;

	// Index three has no register behind it; writes there must be dropped.
	localparam logic [PADDR_W-1:0] ADDR_NO_REG = {2'd3, 2'b00};

	localparam bit KEEP      = 1'b0;
	localparam bit PROGRAM   = 1'b1;
	localparam bit PREDICTED = 1'b0;
	localparam bit TYPED     = 1'b1;

	typedef struct packed {
		logic [COORD_BITS-1:0] q_start;
		logic [COORD_BITS-1:0] q_end;
		logic [COORD_BITS-1:0] s_start;
		logic [COORD_BITS-1:0] s_end;
		logic [SCORE_W-1:0]    score;
		logic                  last;
	} fragment_t;

	typedef struct packed {
		bit                 reprogram;
		logic [CFG_W-1:0]   mismatch;
		logic [CFG_W-1:0]   gap_open;
		logic [CFG_W-1:0]   gap_extend;
		fragment_t          frag;
		bit                 typed;
		logic [OUT_W-1:0]   score;
	} directed_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  fragment_valid = 1'b0;
	logic                  fragment_ready;
	logic [COORD_BITS-1:0] query_start = '0;
	logic [COORD_BITS-1:0] query_end = '0;
	logic [COORD_BITS-1:0] subject_start = '0;
	logic [COORD_BITS-1:0] subject_end = '0;
	logic [SCORE_W-1:0]    fragment_score = '0;
	logic                  last_fragment = 1'b0;
	logic                  chain_valid;
	logic                  chain_ready = 1'b0;
	logic [OUT_W-1:0]      chain_score;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [PADDR_W-1:0]    paddr = '0;
	logic [PDATA_W-1:0]    pwdata = '0;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;

	fragment_chain_affine_gap_score_core #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.fragment_valid(fragment_valid),
		.fragment_ready(fragment_ready),
		.query_start   (query_start),
		.query_end     (query_end),
		.subject_start (subject_start),
		.subject_end   (subject_end),
		.fragment_score(fragment_score),
		.last_fragment (last_fragment),
		.chain_valid   (chain_valid),
		.chain_ready   (chain_ready),
		.chain_score   (chain_score),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor state: penalty registers and the chain in progress.
	logic [CFG_W-1:0]      pen_mismatch = MISMATCH_RESET;
	logic [CFG_W-1:0]      pen_gap_open = GAP_OPEN_RESET;
	logic [CFG_W-1:0]      pen_gap_extend = GAP_EXTEND_RESET;
	bit                    chain_open = 1'b0;
	logic [COORD_BITS-1:0] prev_q_end = '0;
	logic [COORD_BITS-1:0] prev_s_end = '0;
	longint                run_score = 0;

	logic [OUT_W-1:0] pending_scores[$];
	logic [OUT_W-1:0] oldest_score;
	int unsigned      score_errors = 0;
	int unsigned      cycle_count = 0;
	int unsigned      idle_pct = 0;
	int unsigned      stall_pct = 0;
	int unsigned      hold_reqs = 0;
	int unsigned      holds_served = 0;
	int unsigned      hold_left = 0;

	directed_row_t directed_rows [19] = '{
		// single-fragment chains at both extremes
		'{KEEP, '0, '0, '0, '{0, 0, 0, 0, 0, 1'b1}, TYPED, 47'd0},
		'{KEEP, '0, '0, '0, '{C_MAX, C_MAX, C_MAX, C_MAX, S_MAX, 1'b1}, TYPED, 47'hFFFF_FFFF},
		// two fragments, subject side shifted
		'{KEEP, '0, '0, '0, '{0, 100, 0, 100, 1000, 1'b0}, PREDICTED, '0},
		'{KEEP, '0, '0, '0, '{110, 200, 105, 195, 500, 1'b1}, PREDICTED, '0},
		// overlapping fragments give a negative distance, taken as zero
		'{KEEP, '0, '0, '0, '{10, 50, 300, 340, 70000, 1'b0}, PREDICTED, '0},
		'{KEEP, '0, '0, '0, '{40, 90, 350, 400, 20, 1'b0}, PREDICTED, '0},
		'{KEEP, '0, '0, '0, '{95, 150, 380, 420, 30, 1'b1}, PREDICTED, '0},
		// half-unit mismatch penalties land exactly on rounding ties
		'{PROGRAM, 24'd128, 24'd384, 24'd128, '{0, 10, 0, 10, 100, 1'b0}, PREDICTED, '0},
		'{KEEP, '0, '0, '0, '{11, 20, 12, 22, 100, 1'b0}, PREDICTED, '0},
		'{KEEP, '0, '0, '0, '{23, 30, 26, 33, 100, 1'b1}, PREDICTED, '0},
		// widest diagonal shift with top penalties saturates and drives the score negative
		'{PROGRAM, P_MAX, P_MAX, P_MAX, '{0, C_MAX, 0, 0, 5, 1'b0}, PREDICTED, '0},
		'{KEEP, '0, '0, '0, '{0, 0, C_MAX, 0, S_MAX, 1'b1}, TYPED, 47'd0},
		// free junctions: the chain is the plain sum of scores
		'{PROGRAM, '0, '0, '0, '{C_MAX, C_MAX, 0, 0, S_MAX, 1'b0}, PREDICTED, '0},
		'{KEEP, '0, '0, '0, '{0, 0, C_MAX, C_MAX, S_MAX, 1'b0}, PREDICTED, '0},
		'{KEEP, '0, '0, '0, '{5, 6, 7, 8, 0, 1'b1}, TYPED, 47'h1_FFFF_FFFE},
		// largest mismatch rate over the longest subject distance
		'{PROGRAM, P_MAX, '0, '0, '{0, 0, 0, 0, 7, 1'b0}, PREDICTED, '0},
		'{KEEP, '0, '0, '0, '{C_MAX, C_MAX, C_MAX, C_MAX, S_MAX, 1'b1}, PREDICTED, '0},
		'{PROGRAM, 24'd256, 24'd0, 24'd256, '{1000, 2000, 5000, 6000, 3000, 1'b0},
			PREDICTED, '0},
		'{KEEP, '0, '0, '0, '{2100, 2500, 6050, 6450, 400, 1'b1}, PREDICTED, '0}
	};

	// round((base + rate*count) / 2^FRAC_BITS), ties to even, saturated to the penalty width.
	function automatic longint unsigned rounded_penalty(input logic [CFG_W-1:0] base,
			input logic [CFG_W-1:0] rate, input longint unsigned count);
		logic [65:0] scaled;
		logic [65:0] whole;
		scaled = 66'(base) + 66'(rate) * 66'(count);
		whole = scaled >> FRAC_BITS;
		if (scaled[FRAC_BITS-1:0] > HALF_ULP ||
				(scaled[FRAC_BITS-1:0] == HALF_ULP && whole[0]))
			whole = whole + 66'd1;
		if (whole > 66'(PEN_SAT))
			whole = 66'(PEN_SAT);
		return whole[63:0];
	endfunction

	// Advances the chain by one fragment; returns 1 with the chain score on a last fragment.
	function automatic bit score_fragment(input fragment_t f, output logic [OUT_W-1:0] result);
		longint diag_prev;
		longint diag_cur;
		longint shift;
		longint overhang;
		longint sum;
		result = '0;
		if (!chain_open) begin
			run_score = longint'(f.score);
			chain_open = 1'b1;
		end else begin
			diag_prev = longint'(prev_q_end) - longint'(prev_s_end);
			diag_cur = longint'(f.q_start) - longint'(f.s_start);
			shift = diag_prev - diag_cur;
			if (shift < 0)
				shift = -shift;
			// The distance is measured on the side the previous diagonal leans toward.
			if (diag_prev > diag_cur)
				overhang = longint'(f.q_start) - longint'(prev_q_end);
			else
				overhang = longint'(f.s_start) - longint'(prev_s_end);
			if (overhang < 0)
				overhang = 0;
			sum = run_score + longint'(f.score);
			sum = sum - longint'(rounded_penalty(pen_gap_open, pen_gap_extend, shift));
			sum = sum - longint'(rounded_penalty('0, pen_mismatch, overhang));
			if (sum > RUN_MAX)
				sum = RUN_MAX;
			if (sum < RUN_MIN)
				sum = RUN_MIN;
			run_score = sum;
		end
		prev_q_end = f.q_end;
		prev_s_end = f.s_end;
		if (!f.last)
			return 1'b0;
		if (run_score <= 0)
			result = '0;
		else if (run_score > longint'(OUT_MAX))
			result = OUT_MAX;
		else
			result = run_score[OUT_W-1:0];
		chain_open = 1'b0;
		prev_q_end = '0;
		prev_s_end = '0;
		run_score = 0;
		return 1'b1;
	endfunction

	function automatic logic [CFG_W-1:0] pick_penalty();
		case ($urandom_range(5))
			0, 1, 2: return CFG_W'($urandom_range(0, 1023));
			3: return CFG_W'($urandom);
			4: return '0;
			default: return P_MAX;
		endcase
	endfunction

	// Leaves psel high between writes so that it changes only once per step.
	task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
		logic [PDATA_W-1:0] word;
		word = $urandom;
		word[CFG_W-1:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic program_penalties(input logic [CFG_W-1:0] mismatch,
			input logic [CFG_W-1:0] gap_open, input logic [CFG_W-1:0] gap_extend);
		write_register({REG_MISMATCH, 2'b00}, mismatch);
		write_register({REG_GAP_OPEN, 2'b00}, gap_open);
		write_register({REG_GAP_EXTEND, 2'b00}, gap_extend);
		write_register(ADDR_NO_REG, CFG_W'($urandom));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		pen_mismatch = mismatch;
		pen_gap_open = gap_open;
		pen_gap_extend = gap_extend;
	endtask

	task automatic send_fragment(input fragment_t f, input bit typed,
			input logic [OUT_W-1:0] typed_score);
		logic [OUT_W-1:0] predicted;
		while ($urandom_range(99) < idle_pct) begin
			fragment_valid <= 1'b0;
			@(posedge clk);
		end
		fragment_valid <= 1'b1;
		query_start <= f.q_start;
		query_end <= f.q_end;
		subject_start <= f.s_start;
		subject_end <= f.s_end;
		fragment_score <= f.score;
		last_fragment <= f.last;
		do @(posedge clk); while (!fragment_ready);
		if (score_fragment(f, predicted))
			pending_scores = {pending_scores, (typed ? typed_score : predicted)};
	endtask

	// Non-last items leave no result behind, so allow the pipeline to empty after the queue.
	task automatic wait_until_idle();
		fragment_valid <= 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly collinear chains with small gaps and overlaps; one in ten is random noise.
	task automatic send_random_chain(inout int unsigned sent);
		fragment_t f;
		int unsigned len;
		bit noisy;
		logic [COORD_BITS-1:0] q;
		logic [COORD_BITS-1:0] s;
		logic [COORD_BITS-1:0] span;
		len = $urandom_range(1, 8);
		noisy = ($urandom_range(9) == 0);
		q = COORD_BITS'($urandom);
		s = COORD_BITS'($urandom);
		for (int k = 0; k < len; k++) begin
			if (noisy) begin
				f.q_start = COORD_BITS'($urandom);
				f.q_end = COORD_BITS'($urandom);
				f.s_start = COORD_BITS'($urandom);
				f.s_end = COORD_BITS'($urandom);
				f.score = $urandom;
			end else begin
				span = COORD_BITS'($urandom_range(10, 2000));
				f.q_start = q;
				f.q_end = q + span;
				f.s_start = s;
				f.s_end = s + span + COORD_BITS'($urandom_range(0, 40)) - COORD_BITS'(20);
				f.score = ($urandom_range(19) == 0) ? $urandom : $urandom_range(0, 5000);
				q = f.q_end + COORD_BITS'($urandom_range(0, 300)) - COORD_BITS'(50);
				s = f.s_end + COORD_BITS'($urandom_range(0, 300)) - COORD_BITS'(50);
			end
			f.last = (k == len - 1);
			send_fragment(f, PREDICTED, '0);
			sent++;
		end
	endtask

	// Receiver: random stalls, plus a long hold-off on request from the stimulus.
	always @(posedge clk) begin
		if (hold_reqs != holds_served) begin
			holds_served <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			chain_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			chain_ready <= 1'b0;
		end else begin
			chain_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && chain_valid && chain_ready) begin
			if (pending_scores.size() == 0) begin
				score_errors++;
				if (score_errors <= MAX_REPORTS)
					$display("chain score %0d arrived with no chain pending", chain_score);
			end else begin
				oldest_score = pending_scores.pop_front();
				if (chain_score !== oldest_score) begin
					score_errors++;
					if (score_errors <= MAX_REPORTS)
						$display("chain score mismatch: expected %0d, got %0d",
							oldest_score, chain_score);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run timed out after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int unsigned phase_items;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].reprogram) begin
				wait_until_idle();
				program_penalties(directed_rows[i].mismatch, directed_rows[i].gap_open,
					directed_rows[i].gap_extend);
			end
			send_fragment(directed_rows[i].frag, directed_rows[i].typed,
				directed_rows[i].score);
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_until_idle();
			program_penalties(pick_penalty(), pick_penalty(), pick_penalty());
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 78; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 78; end
				default: begin idle_pct = 35; stall_pct = 35; end
			endcase
			// Output blocked while the sender keeps pushing: the input has to back up.
			if (ph == PRESSURE_PHASE)
				hold_reqs++;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS)
				send_random_chain(phase_items);
		end

		wait_until_idle();
		if (score_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[files.f]
design/fcags_pkg.sv
design/fcags_penalty.sv
design/fragment_chain_affine_gap_score_core.sv
sim/tb_fragment_chain_affine_gap_score_core.sv
